// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

// ----- rtl/urde_pkg.sv -----
// ----------------------------------------------------------------------------
// urde_pkg
// Codes, constants, types and the CRC-8 step of the datagram engine.
// ----------------------------------------------------------------------------
package urde_pkg;

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_RX    = 2'd2;
  localparam logic [1:0] CMD_TICK  = 2'd3;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
  localparam logic [1:0] STATUS_TIMEOUT = 2'd2;

  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic CFG_NODE_ADDR = 1'b0;
  localparam logic CFG_TIMEOUT   = 1'b1;

  localparam logic [7:0] SYNC_BYTE = 8'h05;
  localparam logic [7:0] CRC_POLY  = 8'h07;

  localparam logic [3:0] WRITE_LEN  = 4'd8;
  localparam logic [3:0] READ_LEN   = 4'd4;
  localparam logic [3:0] REPORT_LEN = 4'd1;

  // One burst of results handed from the receive tracker to the output queue.
  // The payload bytes stand MSB first; the CRC byte is not included.
  typedef struct packed {
    logic        en;
    logic        kind;
    logic [3:0]  count;
    logic [55:0] bytes;
    logic [31:0] data;
    logic [1:0]  status;
  } load_t;

  // CRC-8, polynomial 0x07, data bits taken LSB first.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
    logic [7:0] crc;
    logic       fb;
    crc = crc_in;
    for (int i = 0; i < 8; i++) begin
      fb  = crc[7] ^ data[i];
      crc = {crc[6:0], 1'b0};
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

endpackage

// ----- rtl/urde_rx_tracker.sv -----
// ----------------------------------------------------------------------------
// urde_rx_tracker
// Command decode and read-transaction tracking: echo, reply and timeout.
// ----------------------------------------------------------------------------
module urde_rx_tracker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic [1:0]         command_i,
  input  logic [6:0]         reg_addr_i,
  input  logic [31:0]        write_data_i,
  input  logic [7:0]         rx_byte_i,
  input  logic [7:0]         node_address_i,
  input  logic [15:0]        timeout_ticks_i,
  output urde_pkg::load_t    load_o
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_ECHO  = 2'd1;
  localparam logic [1:0] PH_REPLY = 2'd2;

  localparam logic [2:0] ECHO_LAST  = 3'd3;
  localparam logic [2:0] REPLY_LAST = 3'd7;
  localparam logic [2:0] DATA_FIRST = 3'd3;

  localparam logic [1:0] CMD_WRITE_SEL = urde_pkg::CMD_WRITE;
  localparam logic [1:0] CMD_READ_SEL  = urde_pkg::CMD_READ;
  localparam logic [1:0] CMD_RX_SEL    = urde_pkg::CMD_RX;
  localparam logic [1:0] CMD_TICK_SEL  = urde_pkg::CMD_TICK;

  logic [1:0]  phase_q, phase_d;
  logic [2:0]  count_q, count_d;
  logic [7:0]  crc_q, crc_d;
  logic [31:0] value_q, value_d;
  logic [15:0] timer_q, timer_d;
  logic [15:0] timer_inc;
  logic        in_read;

  assign timer_inc = timer_q + 16'd1;
  assign in_read   = (phase_q == PH_ECHO) || (phase_q == PH_REPLY);

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    crc_d   = crc_q;
    value_d = value_q;
    timer_d = timer_q;
    load_o  = '0;
    unique case (command_i)
      CMD_WRITE_SEL: begin
        phase_d      = PH_IDLE;
        count_d      = '0;
        crc_d        = '0;
        value_d      = '0;
        timer_d      = '0;
        load_o.en    = 1'b1;
        load_o.kind  = urde_pkg::KIND_TX;
        load_o.count = urde_pkg::WRITE_LEN;
        load_o.bytes = {urde_pkg::SYNC_BYTE, node_address_i, 1'b1, reg_addr_i, write_data_i};
      end
      CMD_READ_SEL: begin
        phase_d      = PH_ECHO;
        count_d      = '0;
        crc_d        = '0;
        value_d      = '0;
        timer_d      = '0;
        load_o.en    = 1'b1;
        load_o.kind  = urde_pkg::KIND_TX;
        load_o.count = urde_pkg::READ_LEN;
        load_o.bytes = {urde_pkg::SYNC_BYTE, node_address_i, 1'b0, reg_addr_i, 32'h0};
      end
      CMD_RX_SEL: begin
        if (phase_q == PH_ECHO) begin
          if (count_q == ECHO_LAST) begin
            // Fourth echoed byte: the reply phase starts with a fresh timer.
            phase_d = PH_REPLY;
            count_d = '0;
            crc_d   = '0;
            value_d = '0;
            timer_d = '0;
          end else begin
            count_d = count_q + 3'd1;
          end
        end else if (phase_q == PH_REPLY) begin
          if (count_q != REPLY_LAST) begin
            crc_d = urde_pkg::crc8_byte(crc_q, rx_byte_i);
            if (count_q >= DATA_FIRST) begin
              value_d = {value_q[23:0], rx_byte_i};
            end
            count_d = count_q + 3'd1;
          end else begin
            load_o.en    = 1'b1;
            load_o.kind  = urde_pkg::KIND_REPORT;
            load_o.count = urde_pkg::REPORT_LEN;
            if (rx_byte_i == crc_q) begin
              load_o.data   = value_q;
              load_o.status = urde_pkg::STATUS_OK;
            end else begin
              load_o.status = urde_pkg::STATUS_CRC_ERR;
            end
            phase_d = PH_IDLE;
            count_d = '0;
            crc_d   = '0;
            value_d = '0;
            timer_d = '0;
          end
        end
      end
      CMD_TICK_SEL: begin
        if (in_read) begin
          // A zero limit behaves as a limit of one; wrap to zero also expires.
          if ((timer_inc >= timeout_ticks_i) || (timer_inc == 16'd0)) begin
            load_o.en     = 1'b1;
            load_o.kind   = urde_pkg::KIND_REPORT;
            load_o.count  = urde_pkg::REPORT_LEN;
            load_o.status = urde_pkg::STATUS_TIMEOUT;
            phase_d = PH_IDLE;
            count_d = '0;
            crc_d   = '0;
            value_d = '0;
            timer_d = '0;
          end else begin
            timer_d = timer_inc;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      count_q <= '0;
      crc_q   <= '0;
      value_q <= '0;
      timer_q <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      crc_q   <= crc_d;
      value_q <= value_d;
      timer_q <= timer_d;
    end
  end

endmodule

// ----- rtl/urde_tx_queue.sv -----
// ----------------------------------------------------------------------------
// urde_tx_queue
// Output register that plays out one burst of results, appending the CRC-8 to transmit bursts.
// ----------------------------------------------------------------------------
module urde_tx_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  urde_pkg::load_t    load_i,
  output logic               can_load_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               kind_o,
  output logic [7:0]         tx_byte_o,
  output logic               last_o,
  output logic [31:0]        read_data_o,
  output logic [1:0]         status_o
);

  logic [3:0]  rem_q;
  logic        kind_q;
  logic [55:0] bytes_q;
  logic [7:0]  crc_q;
  logic [31:0] data_q;
  logic [1:0]  status_q;
  logic        take;
  logic        final_one;

  assign final_one   = (rem_q == 4'd1);
  assign out_valid_o = (rem_q != 4'd0);
  assign take        = out_valid_o && out_ready_i;
  assign can_load_o  = !out_valid_o || (take && final_one);

  assign kind_o      = kind_q;
  assign last_o      = (kind_q == urde_pkg::KIND_TX) && final_one;
  assign tx_byte_o   = (kind_q == urde_pkg::KIND_REPORT) ? 8'h00 :
                       (final_one ? crc_q : bytes_q[55:48]);
  assign read_data_o = data_q;
  assign status_o    = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (load_i.en) begin
      rem_q <= load_i.count;
    end else if (take) begin
      rem_q <= rem_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.en) begin
      kind_q   <= load_i.kind;
      bytes_q  <= load_i.bytes;
      data_q   <= load_i.data;
      status_q <= load_i.status;
      crc_q    <= '0;
    end else if (take) begin
      bytes_q <= {bytes_q[47:0], 8'h00};
      crc_q   <= urde_pkg::crc8_byte(crc_q, bytes_q[55:48]);
    end
  end

endmodule

// ----- rtl/uart_register_datagram_engine.sv -----
// ----------------------------------------------------------------------------
// uart_register_datagram_engine
// Master side of a single-wire UART register protocol with CRC-8 datagrams.
// Each request on the input channel is a write command, a read command, a
// byte received from the line or a timer tick. A write produces eight
// transmit results (sync, node address, register with bit 7 set, four data
// bytes MSB first, CRC), a read produces four (sync, node address, register,
// CRC) and opens a read transaction: the four echoed bytes are dropped, the
// eight reply bytes are gathered, and one report result gives the data with
// status ok, CRC error or timeout. Received bytes and ticks outside a read
// produce nothing; a new command abandons a pending read without a report.
// Each request is decoded combinationally and its results loaded into the
// output register, which plays them out at one per cycle while the output is
// ready, and the next request is taken in the cycle the last result of the
// previous one leaves. Requests without results pass at one per cycle while
// the output is empty. Configuration (node address, timeout in ticks) is
// written through the plain write port; the user must do so only while the
// block is idle, which the block itself does not enforce.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uart_register_datagram_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // Request channel.
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [6:0]  reg_addr_i,
  input  logic [31:0] write_data_i,
  input  logic [7:0]  rx_byte_i,
  // Result channel.
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        last_o,
  output logic [31:0] read_data_o,
  output logic [1:0]  status_o
);

  logic [7:0]      node_q;
  logic [15:0]     timeout_q;
  logic            accept;
  urde_pkg::load_t load_raw;
  urde_pkg::load_t load;

  // Configuration registers; an index outside the list cannot occur with a
  // one-bit index, both codes select a register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q    <= 8'd0;
      timeout_q <= 16'd20;
    end else if (cfg_we_i) begin
      if (cfg_index_i == urde_pkg::CFG_NODE_ADDR) begin
        node_q <= cfg_data_i[7:0];
      end else begin
        timeout_q <= cfg_data_i;
      end
    end
  end

  // A request is taken whenever the output register is empty or is handing
  // over its final result in this same cycle.
  assign accept = in_valid_i && in_ready_o;

  urde_rx_tracker u_rx_tracker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .command_i       (command_i),
    .reg_addr_i      (reg_addr_i),
    .write_data_i    (write_data_i),
    .rx_byte_i       (rx_byte_i),
    .node_address_i  (node_q),
    .timeout_ticks_i (timeout_q),
    .load_o          (load_raw)
  );

  // Only a request that is actually taken may load the output register.
  always_comb begin
    load    = load_raw;
    load.en = load_raw.en && accept;
  end

  urde_tx_queue u_tx_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .can_load_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .kind_o      (kind_o),
    .tx_byte_o   (tx_byte_o),
    .last_o      (last_o),
    .read_data_o (read_data_o),
    .status_o    (status_o)
  );

  // The end-of-datagram flag belongs to transmit results only.
  `ASSERT_NEVER(a_last_on_report, out_valid_o && last_o && (kind_o == urde_pkg::KIND_REPORT), "last set on a report")

  // A failed read never carries data, and no undefined status is reported.
  `ASSERT_AT(a_report_fields, (out_valid_o && (kind_o == urde_pkg::KIND_REPORT)) |-> ((status_o == urde_pkg::STATUS_OK) || ((read_data_o == 32'h0) && ((status_o == urde_pkg::STATUS_CRC_ERR) || (status_o == urde_pkg::STATUS_TIMEOUT)))), "bad report fields")

  // A datagram that is not finished keeps the output busy after each result.
  `ASSERT_AT(a_datagram_continues, (out_valid_o && out_ready_i && (kind_o == urde_pkg::KIND_TX) && !last_o) |=> out_valid_o, "datagram cut short")

  // While results are still queued beyond the current one, no request is taken.
  `ASSERT_AT(a_no_overrun, (out_valid_o && !last_o && (kind_o == urde_pkg::KIND_TX)) |-> !in_ready_o, "request taken while a datagram is pending")

endmodule

// ----- dv/uart_register_datagram_engine_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// uart_register_datagram_engine_tb
// Self-checking bench for the UART register datagram engine. Write and read
// requests, received bytes and ticks are driven in bursts. A behavioural
// model in the bench predicts every datagram byte and read report. The
// results are checked field by field in arrival order.
// ----------------------------------------------------------------------------
module uart_register_datagram_engine_tb;

  // Bytes dropped as echo after a read request, and bytes in the reply.
  localparam int ECHO_BYTES  = 4;
  localparam int REPLY_BYTES = 8;

  // Cycles with no handshake on either channel before the run is abandoned.
  // The longest legitimate quiet spell is a sender gap plus a receiver stall
  // plus the settling pause around a register write, all well under this.
  localparam int WATCHDOG_LIMIT = 2000;

  // How a generated read transaction is meant to end.
  localparam int FATE_OK            = 0;
  localparam int FATE_BAD_CRC       = 1;
  localparam int FATE_ABANDON       = 2;
  localparam int FATE_ECHO_TIMEOUT  = 3;
  localparam int FATE_REPLY_TIMEOUT = 4;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_ECHO,
    PH_REPLY
  } read_phase_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [6:0]  reg_addr;
    logic [31:0] write_data;
    logic [7:0]  rx_byte;
  } request_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  tx_byte;
    logic        last;
    logic [31:0] read_data;
    logic [1:0]  status;
  } result_t;

  // Clock, reset and every input of the block start at known values.
  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        cfg_we_i     = 1'b0;
  logic        cfg_index_i  = urde_pkg::CFG_NODE_ADDR;
  logic [15:0] cfg_data_i   = '0;
  logic        in_valid_i   = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i    = urde_pkg::CMD_TICK;
  logic [6:0]  reg_addr_i   = '0;
  logic [31:0] write_data_i = '0;
  logic [7:0]  rx_byte_i    = '0;
  logic        out_valid_o;
  logic        out_ready_i  = 1'b0;
  logic        kind_o;
  logic [7:0]  tx_byte_o;
  logic        last_o;
  logic [31:0] read_data_o;
  logic [1:0]  status_o;

  uart_register_datagram_engine u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .command_i    (command_i),
    .reg_addr_i   (reg_addr_i),
    .write_data_i (write_data_i),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .kind_o       (kind_o),
    .tx_byte_o    (tx_byte_o),
    .last_o       (last_o),
    .read_data_o  (read_data_o),
    .status_o     (status_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Requests waiting to be driven, and results the model says are owed.
  request_t    pending_q [$];
  result_t     awaited_q [$];
  int          mismatch_count = 0;

  // The bench's own copy of the engine state and its two registers. The
  // registers are only changed while the engine is idle, so the model may
  // take the new values as soon as the write has been made.
  read_phase_e m_phase   = PH_IDLE;
  logic [3:0]  m_count   = '0;
  logic [7:0]  m_crc     = '0;
  logic [31:0] m_value   = '0;
  logic [15:0] m_timer   = '0;
  logic [7:0]  m_node    = 8'd0;
  logic [15:0] m_timeout = 16'd20;

  // ---------------------------------------------------------------------------
  // Model of the engine
  // ---------------------------------------------------------------------------

  // CRC-8 over polynomial 0x07, fed with the data bits LSB first.
  function automatic logic [7:0] crc8_lsb_first(input logic [7:0] crc_in,
                                                input logic [7:0] data);
    logic [7:0] crc;
    logic       feedback;
    crc = crc_in;
    for (int i = 0; i < 8; i++) begin
      feedback = crc[7] ^ data[i];
      crc      = {crc[6:0], 1'b0};
      if (feedback) begin
        crc = crc ^ urde_pkg::CRC_POLY;
      end
    end
    return crc;
  endfunction

  // A programmed timeout of zero behaves as a single tick.
  function automatic int ticks_allowed();
    return (m_timeout == 16'd0) ? 1 : int'(m_timeout);
  endfunction

  function automatic void await_result(input logic kind, input logic [7:0] tx,
                                       input logic last, input logic [31:0] data,
                                       input logic [1:0] status);
    awaited_q.push_back('{kind, tx, last, data, status});
  endfunction

  function automatic void model_go_idle();
    m_phase = PH_IDLE;
    m_count = '0;
    m_crc   = '0;
    m_value = '0;
    m_timer = '0;
  endfunction

  // Advances the model by one accepted request and queues what it owes.
  function automatic void model_request(input request_t rq);
    logic [7:0] frame [8];
    logic [7:0] crc;
    int         len;
    case (rq.command)
      urde_pkg::CMD_WRITE, urde_pkg::CMD_READ: begin
        // Any command abandons a pending read without a report.
        model_go_idle();
        frame[0] = urde_pkg::SYNC_BYTE;
        frame[1] = m_node;
        frame[2] = {rq.command == urde_pkg::CMD_WRITE, rq.reg_addr};
        {frame[3], frame[4], frame[5], frame[6]} = rq.write_data;
        len = (rq.command == urde_pkg::CMD_WRITE) ? 8 : 4;
        crc = '0;
        for (int i = 0; i < len - 1; i++) begin
          await_result(urde_pkg::KIND_TX, frame[i], 1'b0, '0, urde_pkg::STATUS_OK);
          crc = crc8_lsb_first(crc, frame[i]);
        end
        await_result(urde_pkg::KIND_TX, crc, 1'b1, '0, urde_pkg::STATUS_OK);
        if (rq.command == urde_pkg::CMD_READ) begin
          m_phase = PH_ECHO;
        end
      end
      urde_pkg::CMD_RX: begin
        if (m_phase == PH_ECHO) begin
          // Echoed bytes are only counted; the timer is not restarted by them.
          m_count = m_count + 1'b1;
          if (m_count >= ECHO_BYTES) begin
            m_phase = PH_REPLY;
            m_count = '0;
            m_crc   = '0;
            m_value = '0;
            m_timer = '0;
          end
        end else if (m_phase == PH_REPLY) begin
          if (m_count < REPLY_BYTES - 1) begin
            // Header bytes enter the CRC but are not otherwise checked.
            m_crc = crc8_lsb_first(m_crc, rq.rx_byte);
            if (m_count >= 3) begin
              m_value = {m_value[23:0], rq.rx_byte};
            end
            m_count = m_count + 1'b1;
          end else begin
            if (rq.rx_byte == m_crc) begin
              await_result(urde_pkg::KIND_REPORT, '0, 1'b0, m_value, urde_pkg::STATUS_OK);
            end else begin
              await_result(urde_pkg::KIND_REPORT, '0, 1'b0, '0, urde_pkg::STATUS_CRC_ERR);
            end
            model_go_idle();
          end
        end
        // A byte received while idle is ignored.
      end
      default: begin
        // Ticks only count while a read is open.
        if (m_phase != PH_IDLE) begin
          m_timer = m_timer + 1'b1;
          if (m_timer >= ticks_allowed() || m_timer == 16'd0) begin
            await_result(urde_pkg::KIND_REPORT, '0, 1'b0, '0, urde_pkg::STATUS_TIMEOUT);
            model_go_idle();
          end
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver
  // ---------------------------------------------------------------------------
  // The sender works in bursts of random length separated by random gaps. A
  // gap of zero joins two bursts, which gives stretches with no idling at
  // all. Valid is only lowered or replaced once the current request has been
  // taken, and the payload holds still until then.
  int burst_left;
  int gap_left;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left <= 1;
      gap_left   <= 0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        // The ports still hold the request that has just been taken.
        model_request('{command_i, reg_addr_i, write_data_i, rx_byte_i});
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left   <= gap_left - 1;
          in_valid_i <= 1'b0;
        end else if (pending_q.size() != 0) begin
          {command_i, reg_addr_i, write_data_i, rx_byte_i} <= pending_q.pop_front();
          in_valid_i <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor and receiver stalls
  // ---------------------------------------------------------------------------
  // The receiver switches now and then between always ready, random stalls
  // and a fixed duty pattern, so that stalls land on every byte of a
  // datagram as well as on reports.
  int stall_mode;
  int mode_left;
  int pattern_pos;

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_mode  <= 0;
      mode_left   <= 0;
      pattern_pos <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (awaited_q.size() == 0) begin
          $error("result arrived with none awaited: kind %0d byte 0x%0h status %0d",
                 kind_o, tx_byte_o, status_o);
          mismatch_count++;
        end else begin
          want = awaited_q.pop_front();
          check_field("kind", want.kind, kind_o);
          check_field("tx_byte", want.tx_byte, tx_byte_o);
          check_field("last", want.last, last_o);
          check_field("read_data", want.read_data, read_data_o);
          check_field("status", want.status, status_o);
        end
      end
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left  <= $urandom_range(20, 150);
      end else begin
        mode_left <= mode_left - 1;
      end
      pattern_pos <= (pattern_pos == 6) ? 0 : pattern_pos + 1;
      case (stall_mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= ($urandom_range(0, 2) != 0);
        default: out_ready_i <= (pattern_pos >= 3);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("[uart_register_datagram_engine] ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  int requests_queued = 0;

  function automatic void push_request(input logic [1:0] command, input logic [6:0] reg_addr,
                                       input logic [31:0] write_data,
                                       input logic [7:0] rx_byte);
    pending_q.push_back('{command, reg_addr, write_data, rx_byte});
    requests_queued++;
  endfunction

  // Received bytes and ticks carry random values in the fields they ignore.
  function automatic void push_rx(input logic [7:0] rx_byte);
    push_request(urde_pkg::CMD_RX, 7'($urandom), $urandom, rx_byte);
  endfunction

  function automatic void push_tick();
    push_request(urde_pkg::CMD_TICK, 7'($urandom), $urandom, 8'($urandom));
  endfunction

  function automatic void push_ticks(input int n);
    for (int i = 0; i < n; i++) begin
      push_tick();
    end
  endfunction

  // Queues a read request and the line traffic that follows it: four echo
  // bytes, seven reply bytes and the reply CRC, cut short for an abandon or
  // timeout, with ticks sprinkled in below the timeout unless it is the end.
  function automatic void queue_read_txn(input logic [6:0] reg_sel, input int fate);
    logic [7:0] crc;
    logic [7:0] b;
    int         spare;
    int         cut;
    int         late;
    crc   = '0;
    spare = ticks_allowed() - 1;
    cut   = (fate == FATE_ABANDON) ? $urandom_range(0, ECHO_BYTES + REPLY_BYTES - 1)
                                   : ECHO_BYTES + REPLY_BYTES;
    late  = $urandom_range(0, REPLY_BYTES - 1);
    push_request(urde_pkg::CMD_READ, reg_sel, $urandom, 8'($urandom));
    if (fate == FATE_ECHO_TIMEOUT) begin
      for (int i = 0; i < $urandom_range(0, ECHO_BYTES - 1); i++) begin
        push_rx(8'($urandom));
      end
      push_ticks(ticks_allowed());
      return;
    end
    for (int i = 0; i < ECHO_BYTES + REPLY_BYTES; i++) begin
      if (i == cut) begin
        return;
      end
      // The timer restarts when the reply phase opens.
      if (i == ECHO_BYTES) begin
        spare = ticks_allowed() - 1;
      end
      if (fate == FATE_REPLY_TIMEOUT && i == ECHO_BYTES + late) begin
        push_ticks(ticks_allowed());
        return;
      end
      if (spare > 0 && $urandom_range(0, 5) == 0) begin
        push_tick();
        spare--;
      end
      if (i < ECHO_BYTES + REPLY_BYTES - 1) begin
        b = 8'($urandom);
      end else if (fate == FATE_BAD_CRC) begin
        b = crc ^ 8'($urandom_range(1, 255));
      end else begin
        b = crc;
      end
      if (i >= ECHO_BYTES) begin
        crc = crc8_lsb_first(crc, b);
      end
      push_rx(b);
    end
  endfunction

  function automatic void queue_random_txn();
    int         pick;
    int         fate;
    logic [31:0] data;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      data = $urandom;
      if ($urandom_range(0, 9) == 0) begin
        data = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      end
      push_request(urde_pkg::CMD_WRITE, 7'($urandom), data, 8'($urandom));
    end else if (pick < 85) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: fate = FATE_OK;
        5, 6:          fate = FATE_BAD_CRC;
        7:             fate = FATE_ABANDON;
        8:             fate = FATE_ECHO_TIMEOUT;
        default:       fate = FATE_REPLY_TIMEOUT;
      endcase
      // Timeouts of over 40 ticks are not driven to expiry; those reads finish cleanly.
      if ((fate == FATE_ECHO_TIMEOUT || fate == FATE_REPLY_TIMEOUT) && ticks_allowed() > 40) begin
        fate = FATE_OK;
      end
      queue_read_txn(7'($urandom), fate);
    end else begin
      // Stray bytes and ticks; mostly ignored, but they land inside a read
      // left open by an abandoned transaction as well. They do not count.
      for (int i = 0; i < $urandom_range(1, 3); i++) begin
        pending_q.push_back('{$urandom_range(0, 1) ? urde_pkg::CMD_RX : urde_pkg::CMD_TICK,
                              7'($urandom), $urandom, 8'($urandom)});
      end
    end
  endfunction

  // Waits until every request has gone in and every owed result has come out,
  // then lets a last request that produces nothing pass as well.
  task automatic wait_engine_drained();
    do begin
      @(posedge clk_i);
    end while (pending_q.size() != 0 || in_valid_i || awaited_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic index, input logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (index == urde_pkg::CFG_NODE_ADDR) begin
      m_node = value[7:0];
    end else begin
      m_timeout = value;
    end
  endtask

  task automatic run_random_phase(input logic [7:0] node, input logic [15:0] timeout,
                                  input int n_requests);
    int target;
    wait_engine_drained();
    cfg_write(urde_pkg::CFG_NODE_ADDR, {8'h00, node});
    cfg_write(urde_pkg::CFG_TIMEOUT, timeout);
    target = requests_queued + n_requests;
    while (requests_queued < target) begin
      queue_random_txn();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, first under the reset values of the registers: writes at
    // the extremes of register and data.
    push_request(urde_pkg::CMD_WRITE, 7'h7F, 32'hFFFF_FFFF, 8'hFF);
    push_request(urde_pkg::CMD_WRITE, 7'h00, 32'h0000_0000, 8'h00);
    // A read that completes and one whose reply CRC is wrong.
    queue_read_txn(7'h2A, FATE_OK);
    queue_read_txn(7'h55, FATE_BAD_CRC);

    // A zero timeout behaves as one tick: the echo wait expires on the first.
    wait_engine_drained();
    cfg_write(urde_pkg::CFG_NODE_ADDR, 16'h00FF);
    cfg_write(urde_pkg::CFG_TIMEOUT, 16'h0000);
    push_rx(8'hFF);
    push_tick();
    queue_read_txn(7'h7F, FATE_ECHO_TIMEOUT);

    // With two ticks allowed, the reply wait expires part way; then a read is
    // abandoned by a following write request.
    wait_engine_drained();
    cfg_write(urde_pkg::CFG_TIMEOUT, 16'd2);
    queue_read_txn(7'h01, FATE_REPLY_TIMEOUT);
    queue_read_txn(7'h40, FATE_ABANDON);
    push_request(urde_pkg::CMD_WRITE, 7'h33, 32'h8000_0001, 8'h5A);

    // Random part over several register settings, extremes among them.
    run_random_phase(8'($urandom), 16'd1, 6);
    run_random_phase(8'h00, 16'hFFFF, 6);
    run_random_phase(8'hFF, 16'($urandom_range(3, 10)), 6);
    run_random_phase(8'($urandom), 16'($urandom_range(2, 30)), 6);
    run_random_phase(8'($urandom), 16'd20, 6);

    wait_engine_drained();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[uart_register_datagram_engine] OK");
    end else begin
      $display("[uart_register_datagram_engine] ERROR");
    end
    $finish;
  end

endmodule

// ----- uart_register_datagram_engine.f -----
+incdir+rtl
rtl/urde_pkg.sv
rtl/urde_rx_tracker.sv
rtl/urde_tx_queue.sv
rtl/uart_register_datagram_engine.sv
dv/uart_register_datagram_engine_tb.sv
